/* hdl/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside of reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

/* hdl/bpse_pkg.sv */
package bpse_pkg;

	localparam int PLANES = 8;
	localparam int ACC_W  = 24;
	localparam int WORD_W = 32;
	localparam int MODULE_WIDTH = 20;

	localparam int ROW_MODULE_COUNT_DEF    = 2;
	localparam int COLUMN_MODULE_COUNT_DEF = 4;

	localparam logic [4:0] LAST_PIXEL  = 5'd19;
	localparam logic [4:0] FIRST_PIXEL = 5'd0;
	localparam logic [4:0] STAGE_GAP_A = 5'd6;
	localparam logic [4:0] STAGE_GAP_B = 5'd13;
	localparam logic [4:0] PULSE_ROW_A = 5'd7;
	localparam logic [4:0] PULSE_ROW_B = 5'd14;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_ROW  = 1'b1;

	typedef struct packed {
		logic [7:0] pixel;
		logic [4:0] pixel_in_module;
		logic [1:0] column_module;
		logic       row_module;
		logic [4:0] row_in_module;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        plane;
		logic              word_kind;
		logic [5:0]        out_row;
		logic [2:0]        slot;
		logic [WORD_W-1:0] word;
		logic              last;
	} out_item_t;

	// Finished segment handed from the accumulator to the emitter.
	typedef struct packed {
		logic [PLANES-1:0][ACC_W-1:0] acc;
		logic [5:0]                   out_row;
		logic [1:0]                   column_module;
		logic                         last_col;
		logic                         top;
		logic [1:0]                   pulses;
	} snap_t;

	// Shift stage of a pixel; stages 0, 7, 15 and 23 stay empty.
	function automatic logic [4:0] stage_of(input logic [4:0] p);
		logic [4:0] s;
		if (p < STAGE_GAP_A) begin
			s = p + 5'd1;
		end else if (p < STAGE_GAP_B) begin
			s = p + 5'd2;
		end else begin
			s = p + 5'd3;
		end
		return s;
	endfunction

endpackage

/* hdl/bpse_stream_if.sv */
interface bpse_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hdl/led_bit_plane_shift_word_encoder.sv */
// Bit-plane shift word encoder: takes one pixel request per cycle and spreads its
// eight brightness bits over eight 24-stage plane words. The twentieth pixel of a
// module segment (pixel_in_module 19) emits 8 data words, planes 0 to 7, with bit 31
// set on the last column module; when that segment ends the row, 8 row-select words
// follow. Words leave one per cycle while the receiver is ready, from a single
// output register, fed from the segment register after the closing pixel has left
// the input register. Pixels enter at one per cycle; a closing pixel waits in the
// input register until the last word of the previous segment (8 words, or 16 at
// row end) has moved into the output register. With full 20-pixel segments those
// words drain while the next segment's pixels come in, so pixels flow at one per
// cycle; closing pixels that arrive before those words have drained stall the input,
// as does a stalled receiver. Positions 20 to 31 are taken and dropped.

module led_bit_plane_shift_word_encoder #(
	parameter int ROW_MODULE_COUNT    = bpse_pkg::ROW_MODULE_COUNT_DEF,
	parameter int COLUMN_MODULE_COUNT = bpse_pkg::COLUMN_MODULE_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bpse_stream_if.sink   pixels,
	bpse_stream_if.source words
);

	// Finished segment, handed from accumulator to emitter.
	logic            snap_valid;
	logic            snap_ready;
	bpse_pkg::snap_t snap;

	// Register the request, fold the pixel into the plane words, close segments.
	bpse_accum #(
		.ROW_MODULE_COUNT    (ROW_MODULE_COUNT),
		.COLUMN_MODULE_COUNT (COLUMN_MODULE_COUNT)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	// Hold the closed segment and advance one word per cycle, while the receiver keeps up, into the output register.
	bpse_emit #(
		.COLUMN_MODULE_COUNT (COLUMN_MODULE_COUNT)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.words      (words)
	);

endmodule

/* hdl/bpse_accum.sv */
module bpse_accum #(
	parameter int ROW_MODULE_COUNT    = bpse_pkg::ROW_MODULE_COUNT_DEF,
	parameter int COLUMN_MODULE_COUNT = bpse_pkg::COLUMN_MODULE_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	bpse_stream_if.sink     pixels,
	output logic            snap_valid,
	input  logic            snap_ready,
	output bpse_pkg::snap_t snap
);

	localparam logic [7:0] TopRow  = 8'(ROW_MODULE_COUNT * bpse_pkg::MODULE_WIDTH - 1);
	localparam logic [3:0] LastCol = 4'(COLUMN_MODULE_COUNT - 1);

	logic                                         valid_s1;
	bpse_pkg::in_item_t                           item_s1;
	logic [bpse_pkg::PLANES-1:0][bpse_pkg::ACC_W-1:0] acc_q;
	logic [bpse_pkg::PLANES-1:0][bpse_pkg::ACC_W-1:0] acc_nx;
	logic [4:0] stage;
	logic       in_range;
	logic       is_end;
	logic       advance;
	logic [5:0] row_sum;
	logic       rim_zero;
	logic       rim_mid;

	assign in_range = item_s1.pixel_in_module < 5'(bpse_pkg::MODULE_WIDTH);
	assign is_end   = item_s1.pixel_in_module == bpse_pkg::LAST_PIXEL;
	assign advance  = valid_s1 && (!is_end || snap_ready);
	assign pixels.ready = !valid_s1 || advance;
	assign stage    = bpse_pkg::stage_of(item_s1.pixel_in_module);

	always_comb begin
		for (int b = 0; b < bpse_pkg::PLANES; b++) begin
			acc_nx[b] = (item_s1.pixel_in_module == bpse_pkg::FIRST_PIXEL) ? '0 : acc_q[b];
			acc_nx[b][stage] = item_s1.pixel[b];
		end
	end

	assign row_sum  = (item_s1.row_module ? 6'(bpse_pkg::MODULE_WIDTH) : 6'd0)
		+ {1'b0, item_s1.row_in_module};
	assign rim_zero = item_s1.row_in_module == 5'd0;
	assign rim_mid  = (item_s1.row_in_module == bpse_pkg::PULSE_ROW_A)
		|| (item_s1.row_in_module == bpse_pkg::PULSE_ROW_B)
		|| (rim_zero && item_s1.row_module);

	assign snap_valid         = valid_s1 && is_end;
	assign snap.acc           = acc_nx;
	assign snap.out_row       = row_sum;
	assign snap.column_module = item_s1.column_module;
	assign snap.last_col      = {2'b00, item_s1.column_module} == LastCol;
	assign snap.top           = {2'b00, row_sum} == TopRow;
	assign snap.pulses        = 2'd1 + {1'b0, rim_zero} + {1'b0, rim_mid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.ready && pixels.valid) begin
			item_s1 <= pixels.payload;
		end
	end

	// Accumulators clear at end of segment, as the snapshot is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (advance && in_range) begin
			acc_q <= is_end ? '0 : acc_nx;
		end
	end

endmodule

/* hdl/bpse_emit.sv */
`include "assert_macros.svh"

module bpse_emit #(
	parameter int COLUMN_MODULE_COUNT = bpse_pkg::COLUMN_MODULE_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            snap_valid,
	output logic            snap_ready,
	input  bpse_pkg::snap_t snap,
	bpse_stream_if.source   words
);

	localparam logic [2:0] RowSlot = 3'(COLUMN_MODULE_COUNT);

	bpse_pkg::snap_t     snap_q;
	logic                busy_q;
	logic [3:0]          idx_q;
	bpse_pkg::out_item_t out_q;
	logic                out_valid_q;
	logic                load_out;
	logic                idx_is_last;
	logic                kind;

	assign kind        = idx_q[3];
	assign idx_is_last = snap_q.last_col ? (idx_q == 4'd15) : (idx_q == 4'd7);
	assign load_out    = busy_q && (!out_valid_q || words.ready);
	assign snap_ready  = !busy_q || (load_out && idx_is_last);

	assign words.valid   = out_valid_q;
	assign words.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (snap_valid && snap_ready) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (load_out) begin
			busy_q <= !idx_is_last;
			idx_q  <= idx_is_last ? 4'd0 : idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			snap_q <= snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (words.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.plane     <= idx_q[2:0];
			out_q.word_kind <= kind ? bpse_pkg::KIND_ROW : bpse_pkg::KIND_DATA;
			out_q.out_row   <= snap_q.out_row;
			out_q.slot      <= kind ? RowSlot : {1'b0, snap_q.column_module};
			out_q.word      <= kind ? {29'd0, snap_q.pulses, snap_q.top}
				: {snap_q.last_col, 7'd0, snap_q.acc[idx_q[2:0]]};
			out_q.last      <= idx_is_last;
		end
	end

	`ASSERT_NEVER(a_row_words_need_last_col, clk, arst_n, busy_q && !snap_q.last_col && idx_q[3])
	`ASSERT_PROP(a_busy_falls_after_last, clk, arst_n, $fell(busy_q) |-> $past(load_out && idx_is_last))
	`ASSERT_PROP(a_idx_wraps, clk, arst_n, (load_out && idx_is_last) |=> (idx_q == 4'd0))

endmodule

/* bench/bpse_word_checker.sv */
// Watches both channels, predicts the plane words of every accepted pixel request
// and compares each accepted word with the oldest prediction still waiting.
module bpse_word_checker #(
	parameter int ROW_MODULE_COUNT    = bpse_pkg::ROW_MODULE_COUNT_DEF,
	parameter int COLUMN_MODULE_COUNT = bpse_pkg::COLUMN_MODULE_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	input  logic                pix_ready,
	input  bpse_pkg::in_item_t  pix_payload,
	input  logic                word_valid,
	input  logic                word_ready,
	input  bpse_pkg::out_item_t word_payload,
	output int                  failures,
	output int                  pending
);

	localparam logic [31:0] ROW_END_FLAG = 32'h8000_0000;

	logic [bpse_pkg::ACC_W-1:0] plane_acc [bpse_pkg::PLANES];
	bpse_pkg::out_item_t        expected_words [$];

	initial begin
		failures = 0;
		pending  = 0;
	end

	// Pixel positions skip the empty stages 0, 7, 15 and 23.
	function automatic logic [4:0] shift_stage(logic [4:0] pos);
		if (pos < bpse_pkg::STAGE_GAP_A) begin
			return pos + 5'd1;
		end
		if (pos < bpse_pkg::STAGE_GAP_B) begin
			return pos + 5'd2;
		end
		return pos + 5'd3;
	endfunction

	task automatic encode_pixel(bpse_pkg::in_item_t px);
		logic [4:0]          st;
		int                  row_full;
		logic                last_col;
		logic                top_row;
		logic [30:0]         pulses;
		bpse_pkg::out_item_t batch [16];
		int                  n;
		n = 0;
		if (px.pixel_in_module >= bpse_pkg::MODULE_WIDTH) begin
			return;
		end
		st = shift_stage(px.pixel_in_module);
		for (int b = 0; b < bpse_pkg::PLANES; b++) begin
			if (px.pixel_in_module == bpse_pkg::FIRST_PIXEL) begin
				plane_acc[b] = '0;
			end
			plane_acc[b][st] = px.pixel[b];
		end
		if (px.pixel_in_module != bpse_pkg::LAST_PIXEL) begin
			return;
		end
		row_full = int'(px.row_module) * bpse_pkg::MODULE_WIDTH + int'(px.row_in_module);
		last_col = (int'(px.column_module) == COLUMN_MODULE_COUNT - 1);
		for (int b = 0; b < bpse_pkg::PLANES; b++) begin
			batch[n].plane     = 3'(b);
			batch[n].word_kind = bpse_pkg::KIND_DATA;
			batch[n].out_row   = 6'(row_full);
			batch[n].slot      = 3'(px.column_module);
			batch[n].word      = {8'd0, plane_acc[b]} | (last_col ? ROW_END_FLAG : 32'd0);
			batch[n].last      = 1'b0;
			plane_acc[b]       = '0;
			n++;
		end
		if (last_col) begin
			top_row = (row_full == ROW_MODULE_COUNT * bpse_pkg::MODULE_WIDTH - 1);
			pulses  = 31'd1;
			if (px.row_in_module == bpse_pkg::FIRST_PIXEL) begin
				pulses++;
			end
			if (px.row_in_module == bpse_pkg::PULSE_ROW_A ||
					px.row_in_module == bpse_pkg::PULSE_ROW_B ||
					(px.row_in_module == bpse_pkg::FIRST_PIXEL && px.row_module != 1'b0)) begin
				pulses++;
			end
			for (int b = 0; b < bpse_pkg::PLANES; b++) begin
				batch[n].plane     = 3'(b);
				batch[n].word_kind = bpse_pkg::KIND_ROW;
				batch[n].out_row   = 6'(row_full);
				batch[n].slot      = 3'(COLUMN_MODULE_COUNT);
				batch[n].word      = {pulses, top_row};
				batch[n].last      = 1'b0;
				n++;
			end
		end
		batch[n-1].last = 1'b1;
		for (int k = 0; k < n; k++) begin
			expected_words.push_back(batch[k]);
		end
	endtask

	task automatic check_word(bpse_pkg::out_item_t got);
		bpse_pkg::out_item_t want;
		if (expected_words.size() == 0) begin
			$error("unexpected word: plane %0d kind %0d row %0d slot %0d word %h",
				got.plane, got.word_kind, got.out_row, got.slot, got.word);
			failures++;
			return;
		end
		want = expected_words.pop_front();
		if (got.plane !== want.plane) begin
			$error("plane: expected %0d, got %0d", want.plane, got.plane);
			failures++;
		end
		if (got.word_kind !== want.word_kind) begin
			$error("word_kind: expected %0d, got %0d", want.word_kind, got.word_kind);
			failures++;
		end
		if (got.out_row !== want.out_row) begin
			$error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
			failures++;
		end
		if (got.slot !== want.slot) begin
			$error("slot: expected %0d, got %0d", want.slot, got.slot);
			failures++;
		end
		if (got.word !== want.word) begin
			$error("word: expected %h, got %h", want.word, got.word);
			failures++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < bpse_pkg::PLANES; b++) begin
				plane_acc[b] = '0;
			end
			expected_words.delete();
			pending = 0;
		end else begin
			// A request taken at this edge cannot show up at the output yet.
			if (word_valid && word_ready) begin
				check_word(word_payload);
			end
			if (pix_valid && pix_ready) begin
				encode_pixel(pix_payload);
			end
			pending = expected_words.size();
		end
	end

endmodule

/* bench/led_bit_plane_shift_word_encoder_tb.sv */
// Stimulus and verdict for the bit-plane encoder. Pixel requests go in at the falling
// edge, the checker beside the block predicts and compares at the rising edge.
module led_bit_plane_shift_word_encoder_tb;

	// Longest receiver hold-off, enough to fill the block and stall its input.
	localparam int HOLD_LEN    = 150;
	// Cycles without any accepted request before the run is abandoned.
	localparam int STALL_LIMIT = 4000;
	// Settle time after the last predicted word has left the block.
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;

	bpse_stream_if #(.payload_t(bpse_pkg::in_item_t))  pix_if ();
	bpse_stream_if #(.payload_t(bpse_pkg::out_item_t)) word_if ();

	int fail_count;
	int pending_words;
	int requests_sent;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int stall_cycles;

	led_bit_plane_shift_word_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_if),
		.words  (word_if)
	);

	bpse_word_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_if.valid),
		.pix_ready    (pix_if.ready),
		.pix_payload  (pix_if.payload),
		.word_valid   (word_if.valid),
		.word_ready   (word_if.ready),
		.word_payload (word_if.payload),
		.failures     (fail_count),
		.pending      (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: stall at random, or hold off for a long stretch on request.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		word_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				word_if.ready <= 1'b0;
			end else begin
				word_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (word_if.valid && word_if.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("led_bit_plane_shift_word_encoder_tb failed");
				$finish;
			end
		end
	end

	function automatic bpse_pkg::in_item_t make_pixel(logic [7:0] value, logic [4:0] pos,
			logic [1:0] colm, logic rowm, logic [4:0] rim);
		bpse_pkg::in_item_t it;
		it.pixel           = value;
		it.pixel_in_module = pos;
		it.column_module   = colm;
		it.row_module      = rowm;
		it.row_in_module   = rim;
		return it;
	endfunction

	// Brightness with the extremes showing up often.
	function automatic logic [7:0] pick_brightness();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offer one pixel request; return at the falling edge after it was taken,
	// with valid still high so back-to-back requests stay seamless.
	task automatic send_pixel(bpse_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(negedge clk);
		end
		pix_if.valid   <= 1'b1;
		pix_if.payload <= it;
		do begin
			@(posedge clk);
		end while (!pix_if.ready);
		@(negedge clk);
		requests_sent++;
	endtask

	// Drop valid and hold the sender until every predicted word has left.
	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		while (pending_words != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One 20-pixel module segment with random content. Sprinkle in noise requests
	// (any position, including out of range), repeated positions, and now and
	// then abandon the segment before its closing pixel.
	task automatic send_segment(logic [1:0] colm, logic rowm, logic [4:0] rim);
		logic dropped;
		dropped = 1'b0;
		for (int p = 0; p < bpse_pkg::MODULE_WIDTH && !dropped; p++) begin
			if ($urandom_range(99) < 6) begin
				send_pixel(make_pixel(8'($urandom), 5'($urandom), 2'($urandom),
					1'($urandom), 5'($urandom)));
			end
			if (p > 0 && $urandom_range(99) < 4) begin
				send_pixel(make_pixel(pick_brightness(), 5'(p - 1), colm, rowm, rim));
			end
			if (p < bpse_pkg::MODULE_WIDTH - 1 && $urandom_range(99) < 2) begin
				dropped = 1'b1;
			end else begin
				send_pixel(make_pixel(pick_brightness(), 5'(p), colm, rowm, rim));
			end
		end
	endtask

	task automatic pick_row(output logic rowm, output logic [4:0] rim);
		rowm = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: rim = 5'd0;
			1: rim = bpse_pkg::PULSE_ROW_A;
			2: rim = bpse_pkg::PULSE_ROW_B;
			3: rim = bpse_pkg::LAST_PIXEL;
			4: rim = 5'($urandom_range(31));
			default: rim = 5'($urandom_range(19));
		endcase
	endtask

	// Walk rows of segments, column by column; sometimes jump to a random column.
	task automatic run_phase(int send_pct, int recv_pct, int target, logic squeeze);
		int         start;
		logic [1:0] colm;
		logic       rowm;
		logic [4:0] rim;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = requests_sent;
		colm  = 2'd0;
		pick_row(rowm, rim);
		if (squeeze) begin
			// Hold the receiver off while the sender keeps pushing.
			hold_requests++;
		end
		while (requests_sent - start < target) begin
			send_segment(colm, rowm, rim);
			if ($urandom_range(99) < 15) begin
				colm = 2'($urandom_range(3));
			end else begin
				colm = colm + 2'd1;
			end
			if (colm == 2'd0) begin
				pick_row(rowm, rim);
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n         = 1'b0;
		pix_if.valid   = 1'b0;
		pix_if.payload = '0;
		requests_sent  = 0;
		send_idle_pct  = 22;
		recv_idle_pct  = 51;
		hold_requests  = 0;
		stall_cycles   = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part.
		// Out-of-range positions: ignored entirely.
		send_pixel(make_pixel(8'hFF, 5'd31, 2'd3, 1'b1, 5'd31));
		send_pixel(make_pixel(8'hAA, 5'd20, 2'd0, 1'b0, 5'd0));
		// A stale bit, then pixel 0 starts the accumulators afresh.
		send_pixel(make_pixel(8'hFF, 5'd5, 2'd0, 1'b0, 5'd0));
		send_pixel(make_pixel(8'h00, bpse_pkg::FIRST_PIXEL, 2'd0, 1'b0, 5'd0));
		// Repeated pixel: the second value overwrites the stage bit.
		send_pixel(make_pixel(8'hFF, 5'd3, 2'd0, 1'b0, 5'd0));
		send_pixel(make_pixel(8'h0F, 5'd3, 2'd0, 1'b0, 5'd0));
		// Positions on both sides of the stage gaps.
		send_pixel(make_pixel(8'h81, 5'd5, 2'd0, 1'b0, 5'd0));
		send_pixel(make_pixel(8'h7E, bpse_pkg::STAGE_GAP_A, 2'd0, 1'b0, 5'd0));
		send_pixel(make_pixel(8'h3C, 5'd12, 2'd0, 1'b0, 5'd0));
		send_pixel(make_pixel(8'hC3, bpse_pkg::STAGE_GAP_B, 2'd0, 1'b0, 5'd0));
		// Closing pixels: data words only, then row ends of every flavor.
		send_pixel(make_pixel(8'hFF, bpse_pkg::LAST_PIXEL, 2'd0, 1'b0, 5'd0));
		send_pixel(make_pixel(8'h5A, bpse_pkg::LAST_PIXEL, 2'd1, 1'b1, 5'd9));
		send_pixel(make_pixel(8'h00, bpse_pkg::LAST_PIXEL, 2'd3, 1'b1, 5'd19));
		send_pixel(make_pixel(8'h55, bpse_pkg::LAST_PIXEL, 2'd3, 1'b1, 5'd0));
		send_pixel(make_pixel(8'hAA, bpse_pkg::LAST_PIXEL, 2'd3, 1'b0, 5'd0));
		send_pixel(make_pixel(8'h01, bpse_pkg::LAST_PIXEL, 2'd3, 1'b0,
			bpse_pkg::PULSE_ROW_A));
		send_pixel(make_pixel(8'h80, bpse_pkg::LAST_PIXEL, 2'd3, 1'b1,
			bpse_pkg::PULSE_ROW_B));
		send_pixel(make_pixel(8'hF0, bpse_pkg::LAST_PIXEL, 2'd3, 1'b0, 5'd19));
		// Row positions beyond the module: used as given.
		send_pixel(make_pixel(8'h0F, bpse_pkg::LAST_PIXEL, 2'd3, 1'b1, 5'd31));
		send_pixel(make_pixel(8'hE7, bpse_pkg::LAST_PIXEL, 2'd3, 1'b1, 5'd20));
		send_pixel(make_pixel(8'h18, bpse_pkg::LAST_PIXEL, 2'd2, 1'b0, 5'd26));
		wait_idle();

		// Random part: swap the idling sides, then run flat out under a long
		// receiver hold-off.
		run_phase(22, 51, 85, 1'b0);
		run_phase(51, 22, 85, 1'b0);
		run_phase(0, 0, 85, 1'b1);

		if (fail_count == 0) begin
			$display("led_bit_plane_shift_word_encoder_tb passed");
		end else begin
			$display("led_bit_plane_shift_word_encoder_tb failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/bpse_pkg.sv
hdl/bpse_stream_if.sv
hdl/bpse_accum.sv
hdl/bpse_emit.sv
hdl/led_bit_plane_shift_word_encoder.sv
bench/bpse_word_checker.sv
bench/led_bit_plane_shift_word_encoder_tb.sv
